>>> rtl/sha_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, round constants and round helper functions.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int unsigned LEN_POS = 56;

    typedef logic [31:0] word_t;

    typedef struct packed {
        logic load_word;
        logic init_state;
        logic round_step;
        logic add_back;
        logic reset_hash;
    } dp_cmd_t;

    function automatic word_t round_k(input logic [5:0] t);
        word_t k;
        case (t)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic word_t init_h(input logic [2:0] i);
        word_t h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

`default_nettype wire

>>> rtl/sha_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Message schedule window, working variables, hash words and one round a cycle.
// ----------------------------------------------------------------------------
module sha_datapath
    import sha_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire dp_cmd_t    cmd,
    input  wire word_t      load_data,
    input  wire logic [5:0] round_idx,
    input  wire logic [2:0] read_idx,
    output word_t           hash_out
);

    word_t w_reg [16];
    word_t v_reg [8];
    word_t h_reg [8];

    word_t s0;
    word_t s1;
    word_t w_new;
    word_t w_cur;
    word_t t1;
    word_t t2;

    always_comb
    begin
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        w_cur = w_reg[0];
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
            + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + round_k(round_idx) + w_cur;
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
            + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_word)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= load_data;
        end
        else if (cmd.round_step)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_new;
        end
        if (cmd.init_state)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (cmd.round_step)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= init_h(3'(i));
            end
        end
        else if (cmd.reset_hash)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= init_h(3'(i));
            end
        end
        else if (cmd.add_back)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
    end

    assign hash_out = h_reg[read_idx];

endmodule

`default_nettype wire

>>> rtl/sha_control.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 controller
// Byte buffering, padding, round sequencing and digest output.
// ----------------------------------------------------------------------------
module sha_control
    import sha_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_valid,
    input  wire logic        last_byte,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       word_index,
    output logic             last_word,
    output dp_cmd_t          cmd,
    output word_t            load_data,
    output logic [5:0]       round_idx
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PAD   = 7'b0000010,
        ST_LOAD  = 7'b0000100,
        ST_ROUND = 7'b0001000,
        ST_ADD   = 7'b0010000,
        ST_OUT   = 7'b0100000,
        ST_LAST  = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] buf_mem [16];
    word_t       load_data_reg;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] len_reg, len_next;
    logic        fin_reg, fin_next;
    logic        two_reg, two_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        pad_done_reg, pad_done_next;
    logic [5:0]  pad_idx;
    logic        pad_we;
    logic [7:0]  pad_data;
    logic        byte_we;
    logic        accept;

    assign accept = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign word_index = cnt_reg[2:0];
    assign last_word = (cnt_reg[2:0] == 3'd7);
    assign round_idx = cnt_reg;
    assign byte_we = accept && byte_valid;
    assign load_data = load_data_reg;

    always_comb
    begin
        pad_idx = cnt_reg;
        pad_we = (state_reg == ST_PAD);
        if (cnt_reg >= 6'(LEN_POS) && !two_reg)
        begin
            pad_data = len_reg[6'(63 - 8 * (cnt_reg - 6'(LEN_POS))) -: 8];
        end
        else if (cnt_reg == fill_reg && !fin_reg)
        begin
            pad_data = PAD_BYTE;
        end
        else
        begin
            pad_data = 8'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_we)
        begin
            buf_mem[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] <= data_byte;
        end
        else if (pad_we && (cnt_reg >= fill_reg || fin_reg))
        begin
            buf_mem[pad_idx[5:2]][{~pad_idx[1:0], 3'b000} +: 8] <= pad_data;
        end
        load_data_reg <= buf_mem[cnt_next[3:0]];
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next = fill_reg;
        len_next = len_reg;
        fin_next = fin_reg;
        two_next = two_reg;
        cnt_next = cnt_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (byte_valid)
                    begin
                        len_next = len_reg + 64'd8;
                        fill_next = fill_reg + 6'd1;
                    end
                    fin_next = last_byte;
                    if (byte_valid && fill_reg == 6'd63)
                    begin
                        cnt_next = '0;
                        two_next = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else if (last_byte)
                    begin
                        fin_next = 1'b0;
                        cnt_next = byte_valid ? fill_reg + 6'd1 : fill_reg;
                        two_next = ((byte_valid ? fill_reg + 6'd1 : fill_reg) >= 6'(LEN_POS));
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    cnt_next = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load_word = 1'b1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd15)
                begin
                    cmd.init_state = 1'b1;
                    cnt_next = '0;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cmd.round_step = 1'b1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                cmd.add_back = 1'b1;
                cnt_next = '0;
                fill_next = '0;
                if (fin_reg && !pad_done_reg)
                begin
                    fin_next = 1'b0;
                    two_next = 1'b0;
                    state_next = ST_PAD;
                end
                else if (two_reg)
                begin
                    two_next = 1'b0;
                    fin_next = 1'b1;
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_IDLE;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    cnt_next = cnt_reg + 6'd1;
                    if (cnt_reg[2:0] == 3'd7)
                    begin
                        cmd.reset_hash = 1'b1;
                        cnt_next = '0;
                        fill_next = '0;
                        len_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (state_reg == ST_LAST)
        begin
            state_next = pad_done_reg ? ST_OUT : ST_IDLE;
            cnt_next = '0;
        end
    end

    always_comb
    begin
        pad_done_next = pad_done_reg;
        if (state_reg == ST_PAD)
        begin
            pad_done_next = !two_reg;
        end
        else if (state_reg == ST_IDLE)
        begin
            pad_done_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg <= '0;
            len_reg <= '0;
            fin_reg <= 1'b0;
            two_reg <= 1'b0;
            cnt_reg <= '0;
            pad_done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            len_reg <= len_next;
            fin_reg <= fin_next;
            two_reg <= two_next;
            cnt_reg <= cnt_next;
            pad_done_reg <= pad_done_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/sha256_stream_hasher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-serial SHA-256 with padding and eight-word digest output.
// ----------------------------------------------------------------------------
// A byte that neither completes a block nor ends the message is taken
// without holding the input off. The byte that completes a block holds the
// input off while the schedule window is loaded, the 64 rounds run on the
// single round unit, the working variables are added back and the block
// returns to idle. On the last item the padding is written one buffer byte a
// cycle, from the first free position to the end of the block, each padded
// block is compressed in the same way, and the eight digest words follow,
// one per accepted item. The round unit sets the throughput.
module sha256_stream_hasher
    import sha_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_valid,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    dp_cmd_t    cmd;
    word_t      load_data;
    logic [5:0] round_idx;

    sha_control u_control (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .last_byte  (last_byte),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .word_index (word_index),
        .last_word  (last_word),
        .cmd        (cmd),
        .load_data  (load_data),
        .round_idx  (round_idx)
    );

    sha_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .load_data (load_data),
        .round_idx (round_idx),
        .read_idx  (word_index),
        .hash_out  (digest_word)
    );

endmodule

`default_nettype wire
